// ===== rtl/vwpr_pkg.sv =====
// ----------------------------------------------------------------------------
// vwpr_pkg
// shared types and constants of the video write pixel renderer
// ----------------------------------------------------------------------------
package vwpr_pkg;

    localparam int BMP_DEPTH  = 6144;
    localparam int ATTR_DEPTH = 768;
    localparam int BMP_AW     = 13;
    localparam int ATTR_AW    = 10;

    localparam logic [13:0] SCREEN_TOP = 14'h1AFF;
    localparam logic [13:0] ATTR_BASE  = 14'h1800;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BMP,
        S_ATR
    } t_state;

    typedef struct packed {
        logic              bmp_we;
        logic [BMP_AW-1:0] bmp_addr;
        logic              attr_we;
        logic [ATTR_AW-1:0] attr_addr;
        logic [7:0]        wdata;
    } t_mem_req;

    typedef struct packed {
        logic       valid;
        logic [7:0] row;
        logic [4:0] col;
        logic       bits_from_mem;
        logic [7:0] bits;
        logic       attr_from_mem;
        logic [7:0] attr;
        logic       flash;
        logic       last;
    } t_tag;

endpackage

// ===== rtl/vwpr_mem.sv =====
// ----------------------------------------------------------------------------
// vwpr_mem
// bitmap and attribute stores, one port each, registered read data
// ----------------------------------------------------------------------------
module vwpr_mem (
    input  logic              i_clk,
    input  vwpr_pkg::t_mem_req i_req,
    output logic [7:0]        o_bmp_rdata,
    output logic [7:0]        o_attr_rdata
);
    import vwpr_pkg::*;

    logic [7:0] bmp_mem  [BMP_DEPTH];
    logic [7:0] attr_mem [ATTR_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.bmp_we) begin
            bmp_mem[i_req.bmp_addr] <= i_req.wdata;
        end
        o_bmp_rdata <= bmp_mem[i_req.bmp_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.attr_we) begin
            attr_mem[i_req.attr_addr] <= i_req.wdata;
        end
        o_attr_rdata <= attr_mem[i_req.attr_addr];
    end

endmodule

// ===== rtl/vwpr_shade.sv =====
// ----------------------------------------------------------------------------
// vwpr_shade
// shared row unit: turns one bitmap byte and one attribute into eight
// palette indices, registered onto the result ports
// ----------------------------------------------------------------------------
module vwpr_shade (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vwpr_pkg::t_tag i_tag,
    input  logic [7:0]    i_bmp_rdata,
    input  logic [7:0]    i_attr_rdata,
    output logic          o_valid,
    output logic [7:0]    o_pixel_row,
    output logic [4:0]    o_column_byte,
    output logic [3:0]    o_pixel_0,
    output logic [3:0]    o_pixel_1,
    output logic [3:0]    o_pixel_2,
    output logic [3:0]    o_pixel_3,
    output logic [3:0]    o_pixel_4,
    output logic [3:0]    o_pixel_5,
    output logic [3:0]    o_pixel_6,
    output logic [3:0]    o_pixel_7,
    output logic          o_last
);
    import vwpr_pkg::*;

    t_tag       r_tag;
    logic [7:0] bits;
    logic [7:0] attr;
    logic [3:0] ink;
    logic [3:0] paper;
    logic [3:0] n_pix [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else begin
            r_tag.valid <= i_tag.valid;
        end
        r_tag.row           <= i_tag.row;
        r_tag.col           <= i_tag.col;
        r_tag.bits_from_mem <= i_tag.bits_from_mem;
        r_tag.bits          <= i_tag.bits;
        r_tag.attr_from_mem <= i_tag.attr_from_mem;
        r_tag.attr          <= i_tag.attr;
        r_tag.flash         <= i_tag.flash;
        r_tag.last          <= i_tag.last;
    end

    always_comb begin
        bits = r_tag.bits_from_mem ? i_bmp_rdata : r_tag.bits;
        attr = r_tag.attr_from_mem ? i_attr_rdata : r_tag.attr;
        if (attr[7] && r_tag.flash) begin
            ink   = attr[6:3];
            paper = {attr[6], attr[2:0]};
        end else begin
            ink   = {attr[6], attr[2:0]};
            paper = attr[6:3];
        end
        for (int p = 0; p < 8; p++) begin
            n_pix[p] = bits[7-p] ? ink : paper;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_tag.valid;
        end
        o_pixel_row   <= r_tag.row;
        o_column_byte <= r_tag.col;
        o_last        <= r_tag.last;
        o_pixel_0     <= n_pix[0];
        o_pixel_1     <= n_pix[1];
        o_pixel_2     <= n_pix[2];
        o_pixel_3     <= n_pix[3];
        o_pixel_4     <= n_pix[4];
        o_pixel_5     <= n_pix[5];
        o_pixel_6     <= n_pix[6];
        o_pixel_7     <= n_pix[7];
    end

endmodule

// ===== rtl/vwpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// vwpr_ctrl
// sequencer: clearing pass, write decode and row issue for the shared unit
// ----------------------------------------------------------------------------
module vwpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [15:0]       i_address,
    input  logic [7:0]        i_value,
    input  logic              i_flash_phase,
    output vwpr_pkg::t_mem_req o_req,
    output vwpr_pkg::t_tag    o_tag
);
    import vwpr_pkg::*;

    t_state              r_state, n_state;
    logic [13:0]         r_addr, n_addr;
    logic [7:0]          r_val, n_val;
    logic                r_flash, n_flash;
    logic [2:0]          r_y, n_y;
    logic [BMP_AW-1:0]   r_clr, n_clr;
    logic                accept;
    logic [13:0]         in_addr;
    logic [7:0]          bmp_line;

    assign in_addr  = i_address[13:0];
    assign accept   = (r_state == S_IDLE) && start;
    assign bmp_line = {r_addr[12:11], r_addr[7:5], r_addr[10:8]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_y     <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_y     <= n_y;
        end
        r_addr  <= n_addr;
        r_val   <= n_val;
        r_flash <= n_flash;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == BMP_AW'(BMP_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    priority if (in_addr > SCREEN_TOP) n_state = S_IDLE;
                    else if (in_addr < ATTR_BASE)      n_state = S_BMP;
                    else                               n_state = S_ATR;
                end
            end
            S_BMP: n_state = S_IDLE;
            S_ATR: begin
                if (r_y == 3'd7) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // counters and transaction capture
    always_comb begin
        n_addr  = accept ? in_addr : r_addr;
        n_val   = accept ? i_value : r_val;
        n_flash = accept ? i_flash_phase : r_flash;
        n_clr   = (r_state == S_CLEAR) ? r_clr + 1'b1 : r_clr;
        n_y     = (r_state == S_ATR) ? r_y + 1'b1 : 3'd0;
    end

    // outputs
    always_comb begin
        busy                = (r_state != S_IDLE);
        o_req.bmp_we        = 1'b0;
        o_req.bmp_addr      = r_addr[12:0];
        o_req.attr_we       = 1'b0;
        o_req.attr_addr     = {r_addr[12:11], r_addr[7:0]};
        o_req.wdata         = r_val;
        o_tag.valid         = 1'b0;
        o_tag.row           = bmp_line;
        o_tag.col           = r_addr[4:0];
        o_tag.bits_from_mem = 1'b0;
        o_tag.bits          = r_val;
        o_tag.attr_from_mem = 1'b1;
        o_tag.attr          = r_val;
        o_tag.flash         = r_flash;
        o_tag.last          = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_req.bmp_we    = 1'b1;
                o_req.bmp_addr  = r_clr;
                o_req.attr_we   = (r_clr < BMP_AW'(ATTR_DEPTH));
                o_req.attr_addr = r_clr[ATTR_AW-1:0];
                o_req.wdata     = 8'h00;
            end
            S_IDLE: begin
            end
            S_BMP: begin
                o_req.bmp_we    = 1'b1;
                o_req.attr_addr = {bmp_line[7:3], r_addr[4:0]};
                o_tag.valid     = 1'b1;
            end
            S_ATR: begin
                o_req.attr_we       = (r_y == 3'd0);
                o_req.attr_addr     = r_addr[9:0];
                o_req.bmp_addr      = {r_addr[9:8], r_y, r_addr[7:0]};
                o_tag.valid         = 1'b1;
                o_tag.row           = {r_addr[9:5], r_y};
                o_tag.bits_from_mem = 1'b1;
                o_tag.attr_from_mem = 1'b0;
                o_tag.last          = (r_y == 3'd7);
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/video_write_pixel_renderer.sv =====
// ----------------------------------------------------------------------------
// video_write_pixel_renderer
// renders cpu writes to an interleaved bitmap / attribute screen into rows
// of eight palette indices
//
//   channel   direction  handshake           payload
//   write     in         start / busy        i_address, i_value, i_flash_phase
//   pixels    out        o_valid strobe      o_pixel_row, o_column_byte,
//                                            o_pixel_0..7, o_last
//
// a bitmap write holds busy while its one row issues, an attribute write
// while its eight rows issue (one store read per row through the single
// bitmap port); an off-screen write does not raise busy. results leave on
// consecutive cycles, the first strobe following the state register, the
// row unit's tag register and its output register. a clearing pass after
// reset zeroes both stores; busy is high throughout. results never stall.
// ----------------------------------------------------------------------------
module video_write_pixel_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_value,
    input  logic        i_flash_phase,
    output logic        o_valid,
    output logic [7:0]  o_pixel_row,
    output logic [4:0]  o_column_byte,
    output logic [3:0]  o_pixel_0,
    output logic [3:0]  o_pixel_1,
    output logic [3:0]  o_pixel_2,
    output logic [3:0]  o_pixel_3,
    output logic [3:0]  o_pixel_4,
    output logic [3:0]  o_pixel_5,
    output logic [3:0]  o_pixel_6,
    output logic [3:0]  o_pixel_7,
    output logic        o_last
);
    import vwpr_pkg::*;

    t_mem_req   req;
    t_tag       tag;
    logic [7:0] bmp_rdata;
    logic [7:0] attr_rdata;

    vwpr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_address     (i_address),
        .i_value       (i_value),
        .i_flash_phase (i_flash_phase),
        .o_req         (req),
        .o_tag         (tag)
    );

    vwpr_mem u_mem (
        .i_clk        (i_clk),
        .i_req        (req),
        .o_bmp_rdata  (bmp_rdata),
        .o_attr_rdata (attr_rdata)
    );

    vwpr_shade u_shade (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tag         (tag),
        .i_bmp_rdata   (bmp_rdata),
        .i_attr_rdata  (attr_rdata),
        .o_valid       (o_valid),
        .o_pixel_row   (o_pixel_row),
        .o_column_byte (o_column_byte),
        .o_pixel_0     (o_pixel_0),
        .o_pixel_1     (o_pixel_1),
        .o_pixel_2     (o_pixel_2),
        .o_pixel_3     (o_pixel_3),
        .o_pixel_4     (o_pixel_4),
        .o_pixel_5     (o_pixel_5),
        .o_pixel_6     (o_pixel_6),
        .o_pixel_7     (o_pixel_7),
        .o_last        (o_last)
    );

endmodule

// ===== rtl/vwpr_checker.sv =====
// ----------------------------------------------------------------------------
// vwpr_checker
// port-level checks of the video write pixel renderer
// ----------------------------------------------------------------------------
module vwpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [15:0] i_address,
    input logic        o_valid,
    input logic [7:0]  o_pixel_row,
    input logic [4:0]  o_column_byte,
    input logic        o_last
);
    import vwpr_pkg::*;

    // rows of one cell leave back to back
    a_rows_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("cell rows not contiguous");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_pixel_row == $past(o_pixel_row) + 8'd1
            && o_column_byte == $past(o_column_byte))
        else $error("cell row sequence broken");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pixel_row < 8'd192)
        else $error("pixel row off screen");

    // an on-screen transaction raises busy in the next cycle
    a_busy_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_address[13:0] <= SCREEN_TOP |=> busy)
        else $error("busy not raised after write");

endmodule

bind video_write_pixel_renderer vwpr_checker u_vwpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_address     (i_address),
    .o_valid       (o_valid),
    .o_pixel_row   (o_pixel_row),
    .o_column_byte (o_column_byte),
    .o_last        (o_last)
);

// ===== bench/vwpr_render_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwpr_render_checker
// watches the write and pixel channels of the video write pixel renderer,
// keeps its own bitmap and attribute stores, predicts the pixel rows that
// each accepted write produces and compares every result in order
// ----------------------------------------------------------------------------
module vwpr_render_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_value,
    input  logic        i_flash_phase,
    input  logic        o_valid,
    input  logic [7:0]  o_pixel_row,
    input  logic [4:0]  o_column_byte,
    input  logic [3:0]  o_pixel_0,
    input  logic [3:0]  o_pixel_1,
    input  logic [3:0]  o_pixel_2,
    input  logic [3:0]  o_pixel_3,
    input  logic [3:0]  o_pixel_4,
    input  logic [3:0]  o_pixel_5,
    input  logic [3:0]  o_pixel_6,
    input  logic [3:0]  o_pixel_7,
    input  logic        o_last,
    output int          o_fail_count,
    output int          o_rows_pending
);
    import vwpr_pkg::*;

    typedef struct packed {
        logic [7:0]      line;
        logic [4:0]      col;
        logic [7:0][3:0] pix;
        logic            last;
    } t_pixel_row;

    logic [7:0] bitmap_mem [BMP_DEPTH];
    logic [7:0] attr_mem   [ATTR_DEPTH];
    t_pixel_row rows_due [$];
    int         mismatches = 0;

    assign o_fail_count = mismatches;

    initial begin
        for (int i = 0; i < BMP_DEPTH; i++) bitmap_mem[i] = 8'h00;
        for (int i = 0; i < ATTR_DEPTH; i++) attr_mem[i] = 8'h00;
    end

    task automatic report_mismatch(input string msg);
        $display("error at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic t_pixel_row render_row(input logic [7:0] line, input logic [4:0] col,
                                              input logic [7:0] bits, input logic [7:0] attr,
                                              input logic flash, input logic last);
        t_pixel_row r;
        logic [3:0] ink;
        logic [3:0] paper;
        logic [3:0] swap;
        ink   = {attr[6], attr[2:0]};
        paper = attr[6:3];
        if (attr[7] && flash) begin
            swap  = ink;
            ink   = paper;
            paper = swap;
        end
        r.line = line;
        r.col  = col;
        for (int p = 0; p < 8; p++) r.pix[p] = bits[7-p] ? ink : paper;
        r.last = last;
        return r;
    endfunction

    task automatic predict_write(input logic [15:0] address, input logic [7:0] value,
                                 input logic flash);
        logic [13:0] a;
        logic [7:0]  r;
        logic [7:0]  line;
        logic [9:0]  cell_idx;
        logic [12:0] off;
        a = address[13:0];
        if (a > SCREEN_TOP) return;
        if (a < ATTR_BASE) begin
            r    = a[12:5];
            line = {r[7:6], r[2:0], r[5:3]};
            bitmap_mem[a[12:0]] = value;
            rows_due.push_back(render_row(line, a[4:0], value,
                                          attr_mem[{line[7:3], a[4:0]}], flash, 1'b1));
        end else begin
            cell_idx = 10'(a - ATTR_BASE);
            attr_mem[cell_idx] = value;
            for (int y = 0; y < 8; y++) begin
                off = {cell_idx[9:8], 3'(y), cell_idx[7:0]};
                rows_due.push_back(render_row({cell_idx[9:5], 3'(y)}, cell_idx[4:0],
                                              bitmap_mem[off], value, flash, y == 7));
            end
        end
    endtask

    task automatic check_row();
        t_pixel_row e;
        logic [7:0][3:0] got_pix;
        got_pix = {o_pixel_7, o_pixel_6, o_pixel_5, o_pixel_4,
                   o_pixel_3, o_pixel_2, o_pixel_1, o_pixel_0};
        if (rows_due.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel row %0d col %0d",
                                      o_pixel_row, o_column_byte));
            return;
        end
        e = rows_due.pop_front();
        if (o_pixel_row !== e.line)
            report_mismatch($sformatf("pixel_row expected %0d got %0d", e.line, o_pixel_row));
        if (o_column_byte !== e.col)
            report_mismatch($sformatf("column_byte at row %0d expected %0d got %0d",
                                      e.line, e.col, o_column_byte));
        for (int p = 0; p < 8; p++) begin
            if (got_pix[p] !== e.pix[p])
                report_mismatch($sformatf("pixel_%0d at row %0d col %0d expected %0h got %0h",
                                          p, e.line, e.col, e.pix[p], got_pix[p]));
        end
        if (o_last !== e.last)
            report_mismatch($sformatf("last at row %0d col %0d expected %0b got %0b",
                                      e.line, e.col, e.last, o_last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) check_row();
            if (start && busy === 1'b0) predict_write(i_address, i_value, i_flash_phase);
        end
        o_rows_pending <= rows_due.size();
    end

endmodule

// ===== bench/tb_video_write_pixel_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_write_pixel_renderer
// drives cpu video memory writes into the renderer: a directed set covering
// store corners, flash swapping, off-screen and aliased addresses, then
// random bursts biased toward a few overlapping cells; the checker predicts
// and compares every pixel row
// ----------------------------------------------------------------------------
module tb_video_write_pixel_renderer;

    import vwpr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_address = 16'h0000;
    logic [7:0]  i_value = 8'h00;
    logic        i_flash_phase = 1'b0;
    logic        o_valid;
    logic [7:0]  o_pixel_row;
    logic [4:0]  o_column_byte;
    logic [3:0]  o_pixel_0;
    logic [3:0]  o_pixel_1;
    logic [3:0]  o_pixel_2;
    logic [3:0]  o_pixel_3;
    logic [3:0]  o_pixel_4;
    logic [3:0]  o_pixel_5;
    logic [3:0]  o_pixel_6;
    logic [3:0]  o_pixel_7;
    logic        o_last;
    int          fail_count;
    int          rows_pending;

    localparam int RANDOM_WRITES = 340;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    video_write_pixel_renderer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_address     (i_address),
        .i_value       (i_value),
        .i_flash_phase (i_flash_phase),
        .o_valid       (o_valid),
        .o_pixel_row   (o_pixel_row),
        .o_column_byte (o_column_byte),
        .o_pixel_0     (o_pixel_0),
        .o_pixel_1     (o_pixel_1),
        .o_pixel_2     (o_pixel_2),
        .o_pixel_3     (o_pixel_3),
        .o_pixel_4     (o_pixel_4),
        .o_pixel_5     (o_pixel_5),
        .o_pixel_6     (o_pixel_6),
        .o_pixel_7     (o_pixel_7),
        .o_last        (o_last)
    );

    vwpr_render_checker u_render_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_address      (i_address),
        .i_value        (i_value),
        .i_flash_phase  (i_flash_phase),
        .o_valid        (o_valid),
        .o_pixel_row    (o_pixel_row),
        .o_column_byte  (o_column_byte),
        .o_pixel_0      (o_pixel_0),
        .o_pixel_1      (o_pixel_1),
        .o_pixel_2      (o_pixel_2),
        .o_pixel_3      (o_pixel_3),
        .o_pixel_4      (o_pixel_4),
        .o_pixel_5      (o_pixel_5),
        .o_pixel_6      (o_pixel_6),
        .o_pixel_7      (o_pixel_7),
        .o_last         (o_last),
        .o_fail_count   (fail_count),
        .o_rows_pending (rows_pending)
    );

    // one write transaction, start held until accepted
    task automatic write_video(input logic [15:0] address, input logic [7:0] value,
                               input logic flash);
        start         <= 1'b1;
        i_address     <= address;
        i_value       <= value;
        i_flash_phase <= flash;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain_rows();
        start <= 1'b0;
        @(posedge i_clk);
        while (rows_pending != 0) @(posedge i_clk);
    endtask

    // biased toward a few cells in the top third so stores get reused
    function automatic logic [15:0] pick_address();
        logic [1:0]  hi;
        logic [13:0] a;
        int          kind;
        hi   = 2'($urandom_range(0, 3));
        kind = $urandom_range(0, 99);
        if (kind < 25)
            a = {1'b0, 2'b00, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 1)),
                 5'($urandom_range(0, 3))};
        else if (kind < 45)
            a = 14'($urandom_range(0, 14'h17FF));
        else if (kind < 65)
            a = ATTR_BASE + 14'({$urandom_range(0, 1), 5'($urandom_range(0, 3))});
        else if (kind < 82)
            a = ATTR_BASE + 14'($urandom_range(0, ATTR_DEPTH - 1));
        else if (kind < 92)
            a = 14'($urandom_range(int'(SCREEN_TOP) + 1, 14'h3FFF));
        else
            a = 14'($urandom_range(0, 14'h3FFF));
        return {hi, a};
    endfunction

    initial begin
        int sent;
        int burst;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_video(16'h1800, 8'h00, 1'b0);
        write_video(16'h0000, 8'h80, 1'b0);
        write_video(16'h1800, 8'hFF, 1'b0);
        write_video(16'h1800, 8'hC7, 1'b1);
        write_video(16'h0000, 8'hA5, 1'b1);
        write_video(16'h0000, 8'h5A, 1'b0);
        write_video(16'h17FF, 8'hFF, 1'b0);
        write_video(16'h1AFF, 8'h3A, 1'b0);
        write_video(16'h1AFF, 8'hBA, 1'b1);
        write_video(16'h1B00, 8'h55, 1'b1);
        write_video(16'h3FFF, 8'hFF, 1'b0);
        write_video(16'hC000, 8'h01, 1'b1);
        write_video(16'hDAFF, 8'h45, 1'b0);
        write_video(16'hFFFF, 8'hAA, 1'b1);
        write_video(16'h0100, 8'h3C, 1'b0);
        write_video(16'h00E0, 8'h0F, 1'b0);
        write_video(16'h0800, 8'hF0, 1'b1);
        write_video(16'h18E0, 8'h47, 1'b0);
        write_video(16'h1900, 8'h78, 1'b1);
        write_video(16'h1000, 8'h00, 1'b0);
        write_video(16'h1A00, 8'h80, 1'b1);
        write_video(16'h1A00, 8'h80, 1'b0);
        write_video(16'h4001, 8'h7E, 1'b1);
        write_video(16'h9801, 8'hE9, 1'b1);
        hold_off(3);

        sent = 0;
        while (sent < RANDOM_WRITES) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < RANDOM_WRITES; k++) begin
                write_video(pick_address(), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
                sent++;
                if (sent == RANDOM_WRITES / 2) drain_rows();
            end
            hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end

        drain_rows();
        repeat (12) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout waiting on the renderer");
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/vwpr_pkg.sv
rtl/vwpr_mem.sv
rtl/vwpr_shade.sv
rtl/vwpr_ctrl.sv
rtl/video_write_pixel_renderer.sv
rtl/vwpr_checker.sv
bench/vwpr_render_checker.sv
bench/tb_video_write_pixel_renderer.sv
